// ===== src/nzbb_pkg.sv =====
// Package for the nonzero pixel bounding box block.
// Holds the flag struct carried between the front and back parts and the
// fixed field widths. No dependencies.
package nzbb_pkg;

  // Fixed widths of the sample fields.
  localparam int SAMPLE_BITS = 32;
  localparam int OFFSET_BITS = 31;

  // A float sample is zero when all bits but the sign are clear.
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAG_MASK = 32'h7FFF_FFFF;

  // Bit positions of the input tuser flags.
  localparam int TUSER_FRAME_START = 0;
  localparam int TUSER_TILE_START  = 1;
  localparam int IN_USER_BITS      = 2;

  // Classified control flags of one pixel, as queued for the back part.
  typedef struct packed {
    logic occupied;
    logic frame_start;
    logic frame_end;
  } nzbb_flags_t;

  localparam int FLAGS_BITS = $bits(nzbb_flags_t);

endpackage

// ===== src/nonzero_pixel_bounding_box.sv =====
// Top level of the nonzero pixel bounding box block.
// Depends on nzbb_pkg, nzbb_front, nzbb_fifo and nzbb_back.
//
// The slave stream carries one pixel per request: tdata holds pixel_x, pixel_y,
// the float sample bits and the cumulative deep sample offset; tuser holds
// frame_start and tile_start; tlast marks the frame's last pixel. For every
// request with tlast set, one box leaves on the master stream: tdata holds
// min x, min y and the exclusive max x and max y, tuser is the empty flag.
// The cfg channel writes deep_mode (0 tests float samples for nonzero, 1 tests
// offset changes); it is always ready. The user must write it between frames;
// the block does not enforce this. One pixel per cycle while s_axis_tready_o
// is high. An accepted pixel is written into the queue; from the queue head it
// is folded into the box and, on a frame's last pixel, loads the output
// register, from which the box is offered.
// Reset clears the box, the previous offset, deep_mode, the queue and the
// output valid. A stalled box waits in the output register; pixels keep
// flowing until a frame's last pixel reaches the head of the two-entry queue,
// then the queue fills and s_axis_tready_o drops.
module nonzero_pixel_bounding_box import nzbb_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Configuration write: bit 0 is deep_mode.
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i,
  // Pixel stream.
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // Fields from bit 0: pixel_x, pixel_y, sample_bits, sample_offset, zero pad.
  input  logic [((2*COORD_BITS+SAMPLE_BITS+OFFSET_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // Fields from bit 0: frame_start, tile_start.
  input  logic [IN_USER_BITS-1:0] s_axis_tuser_i,
  // frame_end.
  input  logic s_axis_tlast_i,
  // Box stream.
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // Fields from bit 0: box_min_x, box_min_y, box_max_x, box_max_y, zero pad.
  output logic [((4*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata_o,
  // Field: box_empty.
  output logic m_axis_tuser_o
);

  localparam int ENTRY_BITS     = 2*COORD_BITS + FLAGS_BITS;
  localparam int OUT_FIELD_BITS = 4*COORD_BITS + 2;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;
  localparam int QUEUE_DEPTH    = 2;

  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_BITS-1:0]  push_data, pop_data;
  logic [COORD_BITS-1:0]  box_min_x, box_min_y;
  logic [COORD_BITS:0]    box_max_x, box_max_y;

  assign cfg_ready_o = 1'b1;

  nzbb_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .pixel_x_i      (s_axis_tdata_i[COORD_BITS-1:0]),
    .pixel_y_i      (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .sample_bits_i  (s_axis_tdata_i[2*COORD_BITS+SAMPLE_BITS-1:2*COORD_BITS]),
    .sample_offset_i(s_axis_tdata_i[2*COORD_BITS+SAMPLE_BITS+OFFSET_BITS-1:
                                    2*COORD_BITS+SAMPLE_BITS]),
    .frame_start_i  (s_axis_tuser_i[TUSER_FRAME_START]),
    .tile_start_i   (s_axis_tuser_i[TUSER_TILE_START]),
    .frame_end_i    (s_axis_tlast_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  nzbb_fifo #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  nzbb_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .box_min_x_o(box_min_x),
    .box_min_y_o(box_min_y),
    .box_max_x_o(box_max_x),
    .box_max_y_o(box_max_y),
    .box_empty_o(m_axis_tuser_o)
  );

  // Pack the box fields, lowest first.
  assign m_axis_tdata_o = {{OUT_PAD_BITS{1'b0}}, box_max_y, box_max_x, box_min_y, box_min_x};

endmodule

// ===== src/nzbb_front.sv =====
// Front part: accepts pixels, holds the mode and previous offset, and
// classifies each pixel as occupied or not. Depends on nzbb_pkg.
module nzbb_front import nzbb_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [COORD_BITS-1:0]              pixel_x_i,
  input  logic [COORD_BITS-1:0]              pixel_y_i,
  input  logic [SAMPLE_BITS-1:0]             sample_bits_i,
  input  logic [OFFSET_BITS-1:0]             sample_offset_i,
  input  logic                               frame_start_i,
  input  logic                               tile_start_i,
  input  logic                               frame_end_i,
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output logic [2*COORD_BITS+FLAGS_BITS-1:0] push_data_o
);

  logic                   deep_mode_q, deep_mode_d;
  logic [OFFSET_BITS-1:0] last_offset_q, last_offset_d;
  logic [OFFSET_BITS-1:0] prev_offset;
  logic                   accept;
  nzbb_flags_t            flags;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // A tile start makes the previous offset read as zero for this pixel.
  assign prev_offset = tile_start_i ? '0 : last_offset_q;

  // Occupancy test for the current mode.
  always_comb begin
    flags.frame_start = frame_start_i;
    flags.frame_end   = frame_end_i;
    if (deep_mode_q) begin
      flags.occupied = (sample_offset_i != prev_offset);
    end else begin
      flags.occupied = |(sample_bits_i & SAMPLE_MAG_MASK);
    end
  end

  assign push_data_o = {pixel_y_i, pixel_x_i, flags};

  // Every accepted pixel leaves its offset behind, in either mode.
  assign last_offset_d = accept ? sample_offset_i : last_offset_q;
  assign deep_mode_d   = cfg_valid_i ? cfg_data_i : deep_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deep_mode_q   <= 1'b0;
      last_offset_q <= '0;
    end else begin
      deep_mode_q   <= deep_mode_d;
      last_offset_q <= last_offset_d;
    end
  end

endmodule

// ===== src/nzbb_fifo.sv =====
// Short queue between the front and back parts. Depends on nzbb_pkg.
// Register-based; one push (not full) and one pop (not empty) per cycle.
module nzbb_fifo import nzbb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/nzbb_back.sv =====
// Back part: folds classified pixels into the bounding box and holds the
// result in an output register until it is taken. Depends on nzbb_pkg.
module nzbb_back import nzbb_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  logic [2*COORD_BITS+FLAGS_BITS-1:0] pop_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [COORD_BITS-1:0]              box_min_x_o,
  output logic [COORD_BITS-1:0]              box_min_y_o,
  output logic [COORD_BITS:0]                box_max_x_o,
  output logic [COORD_BITS:0]                box_max_y_o,
  output logic                               box_empty_o
);

  nzbb_flags_t                  flags;
  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] low_x_q, low_y_q, high_x_q, high_y_q;
  logic signed [COORD_BITS-1:0] low_x_d, low_y_d, high_x_d, high_y_d;
  logic signed [COORD_BITS-1:0] base_low_x, base_low_y, base_high_x, base_high_y;
  logic                         seen_q, seen_d, base_seen;
  logic                         out_valid_q, out_valid_d;
  logic                         pop, out_load;
  logic [COORD_BITS-1:0]        min_x_q, min_y_q, min_x_d, min_y_d;
  logic [COORD_BITS:0]          max_x_q, max_y_q, max_x_d, max_y_d;
  logic                         empty_q, empty_d;

  assign {py, px, flags} = pop_data_i;

  // A frame end entry waits until the output register is free.
  assign pop_ready_o = !flags.frame_end || !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_load    = pop && flags.frame_end;

  // Box update: frame start clears first, then the pixel extends the box.
  always_comb begin
    if (flags.frame_start) begin
      base_seen   = 1'b0;
      base_low_x  = '0;
      base_low_y  = '0;
      base_high_x = '0;
      base_high_y = '0;
    end else begin
      base_seen   = seen_q;
      base_low_x  = low_x_q;
      base_low_y  = low_y_q;
      base_high_x = high_x_q;
      base_high_y = high_y_q;
    end
    seen_d   = base_seen;
    low_x_d  = base_low_x;
    low_y_d  = base_low_y;
    high_x_d = base_high_x;
    high_y_d = base_high_y;
    if (flags.occupied) begin
      seen_d = 1'b1;
      if (!base_seen) begin
        low_x_d  = px;
        low_y_d  = py;
        high_x_d = px;
        high_y_d = py;
      end else begin
        if (px < base_low_x)  low_x_d  = px;
        if (px > base_high_x) high_x_d = px;
        if (py < base_low_y)  low_y_d  = py;
        if (py > base_high_y) high_y_d = py;
      end
    end
  end

  // Result fields with exclusive maximum, all zero for an empty box.
  always_comb begin
    if (seen_d) begin
      min_x_d = low_x_d;
      min_y_d = low_y_d;
      max_x_d = {high_x_d[COORD_BITS-1], high_x_d} + 1'b1;
      max_y_d = {high_y_d[COORD_BITS-1], high_y_d} + 1'b1;
      empty_d = 1'b0;
    end else begin
      min_x_d = '0;
      min_y_d = '0;
      max_x_d = '0;
      max_y_d = '0;
      empty_d = 1'b1;
    end
  end

  // Output valid: set on a load, cleared when the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      low_x_q     <= '0;
      low_y_q     <= '0;
      high_x_q    <= '0;
      high_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        seen_q   <= seen_d;
        low_x_q  <= low_x_d;
        low_y_q  <= low_y_d;
        high_x_q <= high_x_d;
        high_y_q <= high_y_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      empty_q <= empty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign box_min_x_o = min_x_q;
  assign box_min_y_o = min_y_q;
  assign box_max_x_o = max_x_q;
  assign box_max_y_o = max_y_q;
  assign box_empty_o = empty_q;

endmodule

// ===== src/nzbb_checker.sv =====
// Port-level checks for the nonzero pixel bounding box block, bound to the
// top level. Depends on nonzero_pixel_bounding_box.
module nzbb_checker #(
  parameter int COORD_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [((4*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata_o,
  input logic m_axis_tuser_o
);

  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS:0]   max_x;

  assign min_x = m_axis_tdata_o[COORD_BITS-1:0];
  assign max_x = m_axis_tdata_o[3*COORD_BITS:2*COORD_BITS];

  // A stalled box request stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("box request dropped while stalled");

  // A stalled box request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("box payload changed while stalled");

  // An empty box carries all-zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("empty box with nonzero coordinates");

  // A filled box has its exclusive maximum column above its minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> max_x > $signed({min_x[COORD_BITS-1], min_x}))
    else $error("box maximum column not above minimum");

endmodule

bind nonzero_pixel_bounding_box nzbb_checker #(.COORD_BITS(COORD_BITS)) u_nzbb_checker (.*);
